>>> rtl/core/rmth_pkg.sv
// Package: shared types and constants of the running median block.
`timescale 1ns / 1ps
`default_nettype none
package rmth_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_RM,
    S_RM_LAST,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

>>> rtl/core/running_median_two_heaps.sv
// Top level: running median of unsigned values kept in two heaps in memory.
//
//  Channel  Direction  Signals                         Contents
//  s_axis   in         tvalid, tready, tdata, tuser    tdata: value; tuser: opcode
//  m_axis   out        tvalid, tready, tdata, tuser    tdata: median, count; tuser: full_error
//
// One item is handled at a time by a sequencer that walks the heaps in two
// single-port synchronous memories with a registered read. A clear or a rejected
// insert goes straight to the result. An insert compares the new value with each
// parent in the sift-up until a parent outranks it or it reaches the root. A
// rebalance fetches the last entry and sifts it down from the root one level at
// a time (reading a right child only where one exists) until it reaches a leaf
// or no child outranks it, then sifts the removed top up into the other heap.
// The result sits in an output register, so a new transfer is taken while it waits.
// Reset clears the counts and the control state; heap memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps #(
  parameter int unsigned HALF_CAPACITY = 512
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // Fields from bit 0: value (32 bits).
  input  wire logic [rmth_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0: opcode (1 bit).
  input  wire logic                              s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // Fields from bit 0: median (32 bits), count (10 bits), zero padding.
  output      logic [rmth_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Fields from bit 0: full_error (1 bit).
  output      logic                              m_axis_tuser
);
  import rmth_pkg::*;

  // Heap indices run from 1 to HALF_CAPACITY; counts use the same width.
  localparam int unsigned AW = $clog2(HALF_CAPACITY + 1);
  localparam int unsigned TW = AW + 1;
  localparam logic [TW-1:0] FULL_AT = TW'(2 * HALF_CAPACITY - 1);

  // Heap memories: lower half is a max-heap, upper half a min-heap.
  logic [DATA_W-1:0] lo_mem [HALF_CAPACITY+1];
  logic [DATA_W-1:0] up_mem [HALF_CAPACITY+1];
  logic [DATA_W-1:0] lo_rd_q, up_rd_q;

  state_e            state_q, state_d;
  logic              sel_q, sel_d;         // 0 works on the lower heap, 1 on the upper
  logic              second_q, second_d;   // the insert that ends a rebalance
  logic              err_q, err_d;
  logic [AW-1:0]     lo_cnt_q, lo_cnt_d, up_cnt_q, up_cnt_d;
  logic [AW-1:0]     pos_q, pos_d, cidx_q, cidx_d;
  logic [DATA_W-1:0] val_q, val_d, cval_q, cval_d, mv_q, mv_d;
  logic [DATA_W-1:0] lo_top_q, lo_top_d, up_top_q, up_top_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_med_q, out_med_d;
  logic [COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic              out_err_q, out_err_d;

  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] rdata;
  logic [AW-1:0]     cur_cnt;
  logic [DATA_W-1:0] cur_top;
  logic [AW:0]       child_l, child_r;
  logic              has_l, has_r;
  logic [TW-1:0]     total;
  logic [TW+COUNT_W-1:0] total_ext;
  logic              in_xfer, out_free, tgt_upper;
  logic [DATA_W-1:0] in_value;
  logic              need_rebal;
  logic              up_go, up_win, dn_win, r_win;

  function automatic logic ranks_above(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b,
                                       input logic is_max);
    ranks_above = is_max ? (a > b) : (a < b);
  endfunction

  assign in_value  = s_axis_tdata[DATA_W-1:0];
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign rdata     = sel_q ? up_rd_q : lo_rd_q;
  assign cur_cnt   = sel_q ? up_cnt_q : lo_cnt_q;
  assign cur_top   = sel_q ? up_top_q : lo_top_q;
  assign child_l   = {pos_q, 1'b0};
  assign child_r   = child_l + (AW+1)'(1);
  assign has_l     = child_l <= {1'b0, cur_cnt};
  assign has_r     = child_r <= {1'b0, cur_cnt};
  assign total     = TW'(lo_cnt_q) + TW'(up_cnt_q);
  assign total_ext = {{COUNT_W{1'b0}}, total};
  // A value above the lower top goes up; ties and an empty lower half go down.
  assign tgt_upper = (lo_cnt_q != '0) && (in_value > lo_top_q);
  assign need_rebal = sel_q ? (up_cnt_q > lo_cnt_q)
                            : (TW'(lo_cnt_q) > TW'(up_cnt_q) + TW'(1));
  assign up_go     = pos_q > AW'(1);
  assign up_win    = ranks_above(val_q, rdata, !sel_q);
  assign r_win     = ranks_above(rdata, cval_q, !sel_q);
  assign dn_win    = ranks_above(cval_q, val_q, !sel_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-DATA_W-COUNT_W){1'b0}}, out_cnt_q, out_med_q};
  assign m_axis_tuser  = out_err_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == OP_CLEAR || total >= FULL_AT) state_d = S_DONE;
          else state_d = S_UP;
        end
      end
      S_UP: begin
        if (up_go) state_d = S_UP_CMP;
        else if (!second_q && need_rebal) state_d = S_RM;
        else state_d = S_DONE;
      end
      S_UP_CMP: begin
        if (up_win) state_d = S_UP;
        else if (!second_q && need_rebal) state_d = S_RM;
        else state_d = S_DONE;
      end
      S_RM:      state_d = S_RM_LAST;
      S_RM_LAST: state_d = S_DN;
      S_DN:      state_d = has_l ? S_DN_L : S_UP;
      S_DN_L:    state_d = has_r ? S_DN_R : S_DN_CMP;
      S_DN_R:    state_d = S_DN_CMP;
      S_DN_CMP:  state_d = dn_win ? S_DN : S_UP;
      S_DONE:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    sel_d = sel_q;  second_d = second_q;  err_d = err_q;
    lo_cnt_d = lo_cnt_q;  up_cnt_d = up_cnt_q;
    pos_d = pos_q;  cidx_d = cidx_q;  val_d = val_q;  cval_d = cval_q;  mv_d = mv_q;
    mem_re = 1'b0;  mem_raddr = '0;
    mem_we = 1'b0;  mem_waddr = pos_q;  mem_wdata = val_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_med_d = out_med_q;  out_cnt_d = out_cnt_q;  out_err_d = out_err_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          err_d = 1'b0;
          if (s_axis_tuser == OP_CLEAR) begin
            lo_cnt_d = '0;
            up_cnt_d = '0;
          end else if (total >= FULL_AT) begin
            err_d = 1'b1;
          end else begin
            sel_d    = tgt_upper;
            second_d = 1'b0;
            val_d    = in_value;
            if (tgt_upper) begin
              up_cnt_d = up_cnt_q + AW'(1);
              pos_d    = up_cnt_q + AW'(1);
            end else begin
              lo_cnt_d = lo_cnt_q + AW'(1);
              pos_d    = lo_cnt_q + AW'(1);
            end
          end
        end
      end
      S_UP: begin
        if (up_go) begin
          mem_re    = 1'b1;
          mem_raddr = pos_q >> 1;
        end else begin
          mem_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (up_win) begin
          mem_wdata = rdata;
          pos_d     = pos_q >> 1;
        end
      end
      S_RM: begin
        mv_d      = cur_top;
        mem_re    = 1'b1;
        mem_raddr = cur_cnt;
        if (sel_q) up_cnt_d = up_cnt_q - AW'(1);
        else lo_cnt_d = lo_cnt_q - AW'(1);
      end
      S_RM_LAST: begin
        val_d = rdata;
        pos_d = AW'(1);
      end
      S_DN: begin
        if (has_l) begin
          mem_re    = 1'b1;
          mem_raddr = child_l[AW-1:0];
        end else begin
          mem_we = 1'b1;
        end
      end
      S_DN_L: begin
        cval_d = rdata;
        cidx_d = child_l[AW-1:0];
        if (has_r) begin
          mem_re    = 1'b1;
          mem_raddr = child_r[AW-1:0];
        end
      end
      S_DN_R: begin
        if (r_win) begin
          cval_d = rdata;
          cidx_d = child_r[AW-1:0];
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (dn_win) begin
          mem_wdata = cval_q;
          pos_d     = cidx_q;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_med_d   = (lo_cnt_q != '0) ? lo_top_q : '0;
          out_cnt_d   = total_ext[COUNT_W-1:0];
          out_err_d   = err_q;
        end
      end
      default: ;
    endcase
    // The removed top moves into the other heap once its hole has settled.
    if ((state_q == S_DN && !has_l) || (state_q == S_DN_CMP && !dn_win)) begin
      sel_d    = !sel_q;
      second_d = 1'b1;
      val_d    = mv_q;
      if (sel_q) begin
        lo_cnt_d = lo_cnt_q + AW'(1);
        pos_d    = lo_cnt_q + AW'(1);
      end else begin
        up_cnt_d = up_cnt_q + AW'(1);
        pos_d    = up_cnt_q + AW'(1);
      end
    end
  end

  // The heap tops are mirrored in registers whenever the root is written.
  always_comb begin
    lo_top_d = lo_top_q;
    up_top_d = up_top_q;
    if (mem_we && mem_waddr == AW'(1)) begin
      if (sel_q) up_top_d = mem_wdata;
      else lo_top_d = mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && !sel_q) lo_mem[mem_waddr] <= mem_wdata;
    if (mem_re && !sel_q) lo_rd_q <= lo_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && sel_q) up_mem[mem_waddr] <= mem_wdata;
    if (mem_re && sel_q) up_rd_q <= up_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lo_cnt_q    <= '0;
      up_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
      second_q    <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      lo_cnt_q    <= lo_cnt_d;
      up_cnt_q    <= up_cnt_d;
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
      second_q    <= second_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    cidx_q    <= cidx_d;
    val_q     <= val_d;
    cval_q    <= cval_d;
    mv_q      <= mv_d;
    lo_top_q  <= lo_top_d;
    up_top_q  <= up_top_d;
    out_med_q <= out_med_d;
    out_cnt_q <= out_cnt_d;
    out_err_q <= out_err_d;
  end

endmodule
`default_nettype wire

>>> rtl/core/rmth_checker.sv
// Checker: port-level assertions for the running median block, and its bind.
`timescale 1ns / 1ps
`default_nettype none
module rmth_checker #(
  parameter int unsigned HALF_CAPACITY = 512
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [rmth_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tuser
);
  import rmth_pkg::*;

  localparam int unsigned MAXV = 2 * HALF_CAPACITY - 1;
  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(MAXV);
  localparam bit NO_WRAP = (MAXV < (1 << COUNT_W));

  // A rejected insert reports the block at its capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[DATA_W+COUNT_W-1:DATA_W] == FULL_CNT))
    else $error("full_error with a count below capacity");

  // An empty block reports a zero median.
  a_empty_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NO_WRAP && m_axis_tvalid && m_axis_tdata[DATA_W+COUNT_W-1:DATA_W] == '0)
      |-> (m_axis_tdata[DATA_W-1:0] == '0))
    else $error("nonzero median with a zero count");

  // A stalled result keeps its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // The block is idle when it takes an input, so no transfer lands mid-item.
  a_ready_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after a transfer");

endmodule

bind running_median_two_heaps rmth_checker #(.HALF_CAPACITY(HALF_CAPACITY)) u_rmth_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
